>>> src/tws_pkg.sv
// Shared types and constants for the two-wire sensor measurement master.
// No dependencies; imported by the core.
package tws_pkg;

  localparam int TIMEOUT_W = 24;
  localparam int CFG_W     = 24;

  localparam logic [CFG_W-1:0] READY_TIMEOUT_RST = 24'd1680000;
  localparam logic [15:0]      TIMEOUT_READING   = 16'hFFFF;
  localparam logic [3:0]       BITS_PER_BYTE     = 4'd8;

  typedef enum logic [16:0] {
    PH_IDLE = 17'h00001,
    PH_ST1  = 17'h00002,
    PH_ST2  = 17'h00004,
    PH_ST3  = 17'h00008,
    PH_ST4  = 17'h00010,
    PH_ST5  = 17'h00020,
    PH_ST6  = 17'h00040,
    PH_CSET = 17'h00080,
    PH_CHI  = 17'h00100,
    PH_AHI  = 17'h00200,
    PH_ALO  = 17'h00400,
    PH_WAIT = 17'h00800,
    PH_RHI  = 17'h01000,
    PH_RLO  = 17'h02000,
    PH_MSET = 17'h04000,
    PH_MHI  = 17'h08000,
    PH_MLO  = 17'h10000
  } phase_t;

endpackage

>>> src/two_wire_sensor_measure_master_core.sv
// Two-wire sensor measurement master: start pattern, command byte, ack, ready wait, 16-bit read.
// Depends on tws_pkg.
// The result of an accepted item is registered in the output register. Throughput: one item
// per cycle unless the output stalls; the sequencer state advances once per accepted item.
// Reset: synchronous active-low rst_n returns the sequencer to idle, clears counters,
// reading and flags, loads ready_timeout with 1680000 and empties the output register.
module two_wire_sensor_measure_master_core
  import tws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,   // ready_timeout
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,    // [7:0] command_byte, [8] data_line, rest zero
  input  logic [0:0]           in_tuser,    // [0] command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,   // [0] clock_line, [1] data_pull_low, [2] busy_res,
                                            // [18:3] measurement, [19] timed_out, [20] no_ack
  output logic                 out_tlast    // done_res
);

  logic [CFG_W-1:0]     ready_timeout_r;
  phase_t               phase_r, phase_nxt;
  logic [3:0]           bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           cmd_shift_r, cmd_shift_nxt;
  logic [15:0]          rd_shift_r, rd_shift_nxt;
  logic [TIMEOUT_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [15:0]          result_r, result_nxt;
  logic [1:0]           err_r, err_nxt;
  logic                 done_nxt;
  logic                 sck_nxt, pull_nxt;
  logic [TIMEOUT_W:0]   wait_inc;
  logic                 timeout_hit;

  logic                 out_tvalid_r;
  logic [23:0]          out_tdata_r;
  logic                 out_tlast_r;

  logic                 start;
  logic [7:0]           cbyte;
  logic                 line;
  logic                 in_acc;

  assign start  = in_tuser[0];
  assign cbyte  = in_tdata[7:0];
  assign line   = in_tdata[8];
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign wait_inc    = {1'b0, wait_cnt_r} + (TIMEOUT_W+1)'(1);
  assign timeout_hit = (wait_inc >= (TIMEOUT_W+1)'(ready_timeout_r)) || (&wait_cnt_r);

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    cmd_shift_nxt = cmd_shift_r;
    rd_shift_nxt  = rd_shift_r;
    wait_cnt_nxt  = wait_cnt_r;
    result_nxt    = result_r;
    err_nxt       = err_r;
    done_nxt      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          cmd_shift_nxt = cbyte;
          err_nxt       = 2'b00;
          bit_cnt_nxt   = 4'd0;
          wait_cnt_nxt  = '0;
          phase_nxt     = PH_ST1;
        end
      end
      PH_ST1: phase_nxt = PH_ST2;
      PH_ST2: phase_nxt = PH_ST3;
      PH_ST3: phase_nxt = PH_ST4;
      PH_ST4: phase_nxt = PH_ST5;
      PH_ST5: phase_nxt = PH_ST6;
      PH_ST6: begin
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_CSET;
      end
      PH_CSET: phase_nxt = PH_CHI;
      PH_CHI: begin
        cmd_shift_nxt = {cmd_shift_r[6:0], 1'b0};
        bit_cnt_nxt   = bit_cnt_r + 4'd1;
        phase_nxt     = (bit_cnt_nxt == BITS_PER_BYTE) ? PH_AHI : PH_CSET;
      end
      PH_AHI: begin
        if (line) begin
          err_nxt[1] = 1'b1;
        end
        phase_nxt = PH_ALO;
      end
      PH_ALO: begin
        wait_cnt_nxt = '0;
        phase_nxt    = PH_WAIT;
      end
      PH_WAIT: begin
        if (!line) begin
          bit_cnt_nxt  = 4'd0;
          rd_shift_nxt = 16'd0;
          phase_nxt    = PH_RHI;
        end else if (timeout_hit) begin
          result_nxt = TIMEOUT_READING;
          err_nxt[0] = 1'b1;
          done_nxt   = 1'b1;
          phase_nxt  = PH_IDLE;
        end else begin
          wait_cnt_nxt = wait_inc[TIMEOUT_W-1:0];
        end
      end
      PH_RHI: begin
        rd_shift_nxt = {rd_shift_r[14:0], line};
        bit_cnt_nxt  = bit_cnt_r + 4'd1;
        phase_nxt    = PH_RLO;
      end
      PH_RLO: phase_nxt = (bit_cnt_r[2:0] == 3'd0) ? PH_MSET : PH_RHI;
      PH_MSET: phase_nxt = PH_MHI;
      PH_MHI:  phase_nxt = PH_MLO;
      PH_MLO: begin
        if (bit_cnt_r == 4'd0) begin
          result_nxt = rd_shift_r;
          done_nxt   = 1'b1;
          phase_nxt  = PH_IDLE;
        end else begin
          phase_nxt = PH_RHI;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    case (phase_nxt)
      PH_ST1:  begin sck_nxt = 1'b1; pull_nxt = 1'b0; end
      PH_ST2:  begin sck_nxt = 1'b1; pull_nxt = 1'b1; end
      PH_ST3:  begin sck_nxt = 1'b0; pull_nxt = 1'b1; end
      PH_ST4:  begin sck_nxt = 1'b1; pull_nxt = 1'b1; end
      PH_ST5:  begin sck_nxt = 1'b1; pull_nxt = 1'b0; end
      PH_CSET: begin sck_nxt = 1'b0; pull_nxt = ~cmd_shift_nxt[7]; end
      PH_CHI:  begin sck_nxt = 1'b1; pull_nxt = ~cmd_shift_nxt[7]; end
      PH_AHI:  begin sck_nxt = 1'b1; pull_nxt = 1'b0; end
      PH_RHI:  begin sck_nxt = 1'b1; pull_nxt = 1'b0; end
      PH_MSET: begin sck_nxt = 1'b0; pull_nxt = (bit_cnt_nxt == BITS_PER_BYTE); end
      PH_MHI:  begin sck_nxt = 1'b1; pull_nxt = (bit_cnt_nxt == BITS_PER_BYTE); end
      default: begin sck_nxt = 1'b0; pull_nxt = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_timeout_r <= READY_TIMEOUT_RST;
    end else if (cfg_we) begin
      ready_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= 4'd0;
      cmd_shift_r <= 8'd0;
      rd_shift_r  <= 16'd0;
      wait_cnt_r  <= '0;
      result_r    <= 16'd0;
      err_r       <= 2'b00;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cmd_shift_r <= cmd_shift_nxt;
      rd_shift_r  <= rd_shift_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      result_r    <= result_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_tready) begin
      out_tvalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {3'b000, err_nxt[1], err_nxt[0], result_nxt,
                      (phase_nxt != PH_IDLE), pull_nxt, sck_nxt};
      out_tlast_r <= done_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

>>> src/tws_checker.sv
// Port-level checks for the two-wire sensor measurement master core.
// Depends on two_wire_sensor_measure_master_core; attached by the bind below.
module tws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[2] && !out_tdata[0] && !out_tdata[1])
    else $error("done item shows busy or driven lines");

  a_timeout_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[19] |-> out_tdata[18:3] == 16'hFFFF)
    else $error("timeout reading not all ones");

endmodule

bind two_wire_sensor_measure_master_core tws_checker u_tws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/tb_two_wire_sensor_measure_master_core.sv
// Testbench for two_wire_sensor_measure_master_core: drives tick and start items, models the
// sensor's DATA responses, and checks every result against a cycle-exact sequencer predictor.
// Depends on tws_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_two_wire_sensor_measure_master_core
  import tws_pkg::*;
();

  typedef struct packed {
    logic        no_ack;
    logic        timed_out;
    logic [15:0] measurement;
    logic        done;
    logic        busy;
    logic        pull;
    logic        sck;
  } meas_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic out_tlast;

  always #5 clk = ~clk;

  two_wire_sensor_measure_master_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  phase_t               seq_phase;
  logic [3:0]           bit_cnt;
  logic [7:0]           cmd_shift;
  logic [15:0]          rd_shift;
  logic [TIMEOUT_W-1:0] ready_wait;
  logic [15:0]          reading;
  logic                 timed_out_flag;
  logic                 no_ack_flag;
  logic [CFG_W-1:0]     ready_limit;

  meas_result_t expected_levels[$];
  int mismatches = 0;
  int items_sent = 0;
  int send_gap_pct = 0;
  int sink_stall_pct = 0;

  function automatic void reset_sequencer();
    seq_phase      = PH_IDLE;
    bit_cnt        = '0;
    cmd_shift      = '0;
    rd_shift       = '0;
    ready_wait     = '0;
    reading        = '0;
    timed_out_flag = 1'b0;
    no_ack_flag    = 1'b0;
    ready_limit    = READY_TIMEOUT_RST;
  endfunction

  function automatic meas_result_t step_sequencer(input logic cmd, input logic [7:0] cb,
                                                  input logic line);
    meas_result_t r;
    r = '0;
    case (seq_phase)
      PH_IDLE: if (cmd) begin
        cmd_shift      = cb;
        timed_out_flag = 1'b0;
        no_ack_flag    = 1'b0;
        bit_cnt        = '0;
        ready_wait     = '0;
        seq_phase      = PH_ST1;
      end
      PH_ST1: seq_phase = PH_ST2;
      PH_ST2: seq_phase = PH_ST3;
      PH_ST3: seq_phase = PH_ST4;
      PH_ST4: seq_phase = PH_ST5;
      PH_ST5: seq_phase = PH_ST6;
      PH_ST6: begin
        bit_cnt   = '0;
        seq_phase = PH_CSET;
      end
      PH_CSET: seq_phase = PH_CHI;
      PH_CHI: begin
        cmd_shift = cmd_shift << 1;
        bit_cnt   = bit_cnt + 4'd1;
        seq_phase = (bit_cnt == BITS_PER_BYTE) ? PH_AHI : PH_CSET;
      end
      PH_AHI: begin
        if (line) no_ack_flag = 1'b1;
        seq_phase = PH_ALO;
      end
      PH_ALO: begin
        ready_wait = '0;
        seq_phase  = PH_WAIT;
      end
      PH_WAIT: begin
        if (!line) begin
          bit_cnt   = '0;
          rd_shift  = '0;
          seq_phase = PH_RHI;
        end else if (32'(ready_wait) + 32'd1 >= 32'(ready_limit) || &ready_wait) begin
          reading        = TIMEOUT_READING;
          timed_out_flag = 1'b1;
          r.done         = 1'b1;
          seq_phase      = PH_IDLE;
        end else begin
          ready_wait = ready_wait + 1'b1;
        end
      end
      PH_RHI: begin
        rd_shift  = {rd_shift[14:0], line};
        bit_cnt   = bit_cnt + 4'd1;
        seq_phase = PH_RLO;
      end
      PH_RLO: seq_phase = (bit_cnt[2:0] == 3'd0) ? PH_MSET : PH_RHI;
      PH_MSET: seq_phase = PH_MHI;
      PH_MHI: seq_phase = PH_MLO;
      PH_MLO: begin
        if (bit_cnt == 4'd0) begin
          reading   = rd_shift;
          r.done    = 1'b1;
          seq_phase = PH_IDLE;
        end else begin
          seq_phase = PH_RHI;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase

    case (seq_phase)
      PH_ST1:  begin r.sck = 1'b1; r.pull = 1'b0; end
      PH_ST2:  begin r.sck = 1'b1; r.pull = 1'b1; end
      PH_ST3:  begin r.sck = 1'b0; r.pull = 1'b1; end
      PH_ST4:  begin r.sck = 1'b1; r.pull = 1'b1; end
      PH_ST5:  begin r.sck = 1'b1; r.pull = 1'b0; end
      PH_CSET: begin r.sck = 1'b0; r.pull = ~cmd_shift[7]; end
      PH_CHI:  begin r.sck = 1'b1; r.pull = ~cmd_shift[7]; end
      PH_AHI:  begin r.sck = 1'b1; r.pull = 1'b0; end
      PH_RHI:  begin r.sck = 1'b1; r.pull = 1'b0; end
      PH_MSET: begin r.sck = 1'b0; r.pull = (bit_cnt == BITS_PER_BYTE); end
      PH_MHI:  begin r.sck = 1'b1; r.pull = (bit_cnt == BITS_PER_BYTE); end
      default: begin r.sck = 1'b0; r.pull = 1'b0; end
    endcase
    r.busy        = (seq_phase != PH_IDLE);
    r.measurement = reading;
    r.timed_out   = timed_out_flag;
    r.no_ack      = no_ack_flag;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    meas_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_levels.size() == 0) begin
        $error("result with no pending expectation: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        check_field("clock_line", want.sck, out_tdata[0]);
        check_field("data_pull_low", want.pull, out_tdata[1]);
        check_field("busy_res", want.busy, out_tdata[2]);
        check_field("measurement", want.measurement, out_tdata[18:3]);
        check_field("timed_out", want.timed_out, out_tdata[19]);
        check_field("no_ack", want.no_ack, out_tdata[20]);
        check_field("done_res", want.done, out_tlast);
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= sink_stall_pct);

  task automatic send_item(input logic cmd, input logic [7:0] cb, input logic line);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, line, cb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_levels.push_back(step_sequencer(cmd, cb, line));
    items_sent++;
  endtask

  // hold the sender until every result is back, then load the timeout register
  task automatic set_ready_limit(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    ready_limit = value;
  endtask

  task automatic send_idle_ticks(input int n);
    repeat (n) send_item(1'b0, 8'($urandom), 1'($urandom));
  endtask

  // start a transaction and answer as the sensor until the sequencer is idle again
  task automatic run_measurement(input logic [7:0] cb, input bit ack_ok, input int ready_delay,
                                 input logic [15:0] value, input int busy_start_pct,
                                 input bit noisy);
    int highs;
    logic line;
    logic cmd;
    highs = 0;
    send_item(1'b1, cb, 1'($urandom));
    while (seq_phase != PH_IDLE) begin
      line = 1'($urandom);
      if (!noisy) begin
        case (seq_phase)
          PH_AHI:  line = !ack_ok;
          PH_WAIT: begin
            line = (highs < ready_delay);
            if (line) highs++;
          end
          PH_RHI:  line = value[4'd15 - bit_cnt];
          default: ;
        endcase
      end
      cmd = ($urandom_range(99) < busy_start_pct);
      send_item(cmd, 8'($urandom), line);
    end
  endtask

  task automatic test_reset_defaults();
    send_idle_ticks(4);
    run_measurement(8'h00, 1'b1, 3, 16'h1234, 0, 1'b0);
  endtask

  task automatic test_timeout_limits();
    set_ready_limit('0);
    run_measurement(8'h5A, 1'b1, 10, 16'hBEEF, 0, 1'b0);
    set_ready_limit(24'd1);
    run_measurement(8'hC3, 1'b1, 10, 16'hBEEF, 0, 1'b0);
    set_ready_limit(24'd5);
    run_measurement(8'h81, 1'b1, 4, 16'h8001, 0, 1'b0);
    run_measurement(8'h7E, 1'b1, 5, 16'h8001, 0, 1'b0);
  endtask

  task automatic test_ack_and_extremes();
    run_measurement(8'hFF, 1'b0, 0, 16'hFFFF, 0, 1'b0);
    run_measurement(8'h00, 1'b1, 2, 16'h0000, 0, 1'b0);
    set_ready_limit(24'hFFFFFF);
    run_measurement(8'hA5, 1'b1, 30, 16'h5AA5, 0, 1'b0);
  endtask

  task automatic test_start_while_busy();
    run_measurement(8'h3C, 1'b1, 1, 16'hC33C, 100, 1'b0);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int budget);
    int target;
    int kind;
    int delay;
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(5))
          0: set_ready_limit('0);
          1: set_ready_limit(24'd1);
          2: set_ready_limit(24'd2);
          3: set_ready_limit(24'($urandom_range(3, 40)));
          4: set_ready_limit(24'hFFFFFF);
          default: set_ready_limit(24'($urandom_range(41, 24'hFFFFFE)));
        endcase
      end
      if (ready_limit <= 40) delay = $urandom_range(0, ready_limit + 1);
      else delay = $urandom_range(0, 30);
      kind = $urandom_range(9);
      if (kind == 0) begin
        run_measurement(8'($urandom), 1'b1, 0, 16'h0, 20, 1'b1);
      end else if (kind == 1) begin
        send_idle_ticks($urandom_range(1, 5));
      end else begin
        run_measurement(8'($urandom), ($urandom_range(9) != 0), delay, 16'($urandom),
                        ($urandom_range(1) ? 0 : 10), 1'b0);
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    reset_sequencer();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_timeout_limits();
    test_ack_and_extremes();
    test_start_while_busy();
    test_random_traffic(11, 80, 460);
    test_random_traffic(80, 11, 460);
    test_random_traffic(0, 0, 460);

    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_levels.size() != 0) begin
      $error("%0d results never arrived", expected_levels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
